// ----- sv/ordered_array_list_engine_defines.svh -----
// ----------------------------------------------------------------------------
// ordered_array_list_engine_defines
// assertion macros used by the ordered list engine top level
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define OALE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define OALE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define OALE_ASSERT(label, prop, msg)
`define OALE_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- sv/oale_pkg.sv -----
// ----------------------------------------------------------------------------
// oale_pkg
// types and codes shared by the ordered list engine modules
// ----------------------------------------------------------------------------
package oale_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned PayW = 64;
  localparam int unsigned CntW = 9;

  // operation codes
  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE_AT  = 3'd1,
    OP_REMOVE_KEY = 3'd2,
    OP_FIND_KEY   = 3'd3,
    OP_READ_AT    = 3'd4,
    OP_COUNT_KEY  = 3'd5,
    OP_CLEAR      = 3'd6
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_NOKEY  = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SCAN,
    S_FETCH,
    S_DONE
  } seq_state_e;

  // one stored record
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [PayW-1:0]        payload;
  } rec_t;

  // one accepted input transaction
  typedef struct packed {
    op_e                    op;
    logic [CntW-1:0]        position;
    logic signed [KeyW-1:0] key;
    logic [PayW-1:0]        payload;
  } item_t;

  // one result transaction
  typedef struct packed {
    status_e                status;
    logic signed [KeyW-1:0] found_key;
    logic [PayW-1:0]        found_payload;
    logic [CntW-1:0]        match_count;
    logic [CntW-1:0]        list_length;
  } result_t;

endpackage

// ----- sv/oale_mem.sv -----
// ----------------------------------------------------------------------------
// oale_mem
// record memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module oale_mem import oale_pkg::*; #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  rec_t             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output rec_t             rdata_o
);

  rec_t mem_q [Depth];
  rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/oale_seq.sv -----
// ----------------------------------------------------------------------------
// oale_seq
// operation sequencer: decodes a transaction, then shifts or scans the
// record memory one entry per cycle and builds the result
// ----------------------------------------------------------------------------
module oale_seq import oale_pkg::*; #(
  parameter int unsigned Capacity = 256,
  parameter int unsigned AddrW    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  item_t            item_i,
  input  logic [CntW-1:0]  cap_i,
  output logic             busy_o,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output result_t          res_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output rec_t             mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  rec_t             mem_rdata_i
);

  localparam int unsigned CapLimitInt = (Capacity > 511) ? 511 : Capacity;
  localparam logic [CntW-1:0] CapLimit = CntW'(CapLimitInt);

  seq_state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pend_q, pend_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] at_q, at_d;
  logic [CntW-1:0] wr_addr_q, wr_addr_d;
  item_t           item_q;
  status_e         status_q, status_d;
  logic signed [KeyW-1:0] fkey_q, fkey_d;
  logic [PayW-1:0] fpay_q, fpay_d;
  logic [CntW-1:0] match_q, match_d;

  logic [CntW-1:0] cap_used;
  logic            ins_full, ins_badpos, rm_empty, rm_badpos, rd_bad;
  logic [CntW-1:0] ins_at, rm_at;
  logic            key_hit, scan_more, up_more, dn_more;
  logic [CntW-1:0] raddr, waddr;

  // decode conditions
  always_comb begin
    cap_used   = (cap_i > CapLimit) ? CapLimit : cap_i;
    ins_full   = count_q >= cap_used;
    ins_badpos = item_q.position > cap_used;
    ins_at     = (item_q.position < count_q) ? item_q.position : count_q;
    rm_empty   = count_q == '0;
    rm_badpos  = item_q.position >= cap_used;
    rm_at      = (item_q.position < count_q) ? item_q.position : count_q - 1'b1;
    rd_bad     = (item_q.position == '0) || (item_q.position > count_q);
    key_hit    = pend_q && (mem_rdata_i.key == item_q.key);
    scan_more  = idx_q < count_q;
    up_more    = idx_q > at_q;
    dn_more    = ({1'b0, idx_q} + 10'd1) < {1'b0, count_q};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (item_q.op)
          OP_INSERT:     state_d = (ins_full || ins_badpos) ? S_DONE : S_SHIFT_UP;
          OP_REMOVE_AT:  state_d = (rm_empty || rm_badpos) ? S_DONE : S_SHIFT_DN;
          OP_REMOVE_KEY: state_d = rm_empty ? S_DONE : S_SCAN;
          OP_FIND_KEY:   state_d = S_SCAN;
          OP_READ_AT:    state_d = rd_bad ? S_DONE : S_FETCH;
          OP_COUNT_KEY:  state_d = rm_empty ? S_DONE : S_SCAN;
          default:       state_d = S_DONE;
        endcase
      end
      S_SHIFT_UP: begin
        if (!up_more && !pend_q) state_d = S_DONE;
      end
      S_SHIFT_DN: begin
        if (!dn_more && !pend_q) state_d = S_DONE;
      end
      S_SCAN: begin
        if (key_hit && item_q.op == OP_FIND_KEY) begin
          state_d = S_DONE;
        end else if (key_hit && item_q.op == OP_REMOVE_KEY) begin
          state_d = S_SHIFT_DN;
        end else if (!pend_q && !scan_more) begin
          state_d = S_DONE;
        end
      end
      S_FETCH: state_d = S_DONE;
      S_DONE: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d     = count_q;
    pend_d      = pend_q;
    idx_d       = idx_q;
    at_d        = at_q;
    wr_addr_d   = wr_addr_q;
    status_d    = status_q;
    fkey_d      = fkey_q;
    fpay_d      = fpay_q;
    match_d     = match_q;
    mem_we_o    = 1'b0;
    waddr       = wr_addr_q;
    mem_wdata_o = mem_rdata_i;
    raddr       = idx_q;
    unique case (state_q)
      S_DECODE: begin
        status_d = ST_OK;
        fkey_d   = '0;
        fpay_d   = '0;
        match_d  = '0;
        pend_d   = 1'b0;
        idx_d    = '0;
        unique case (item_q.op) inside
          OP_INSERT: begin
            if (ins_full) begin
              status_d = ST_FULL;
            end else if (ins_badpos) begin
              status_d = ST_BADPOS;
            end
            idx_d = count_q;
            at_d  = ins_at;
          end
          OP_REMOVE_AT: begin
            if (rm_empty) begin
              status_d = ST_EMPTY;
            end else if (rm_badpos) begin
              status_d = ST_BADPOS;
            end
            idx_d = rm_at;
          end
          OP_REMOVE_KEY, OP_COUNT_KEY: begin
            if (rm_empty) status_d = ST_EMPTY;
          end
          OP_READ_AT: begin
            if (rd_bad) status_d = ST_BADPOS;
            raddr = item_q.position - 1'b1;
          end
          OP_CLEAR: count_d = '0;
          default: ;
        endcase
      end
      // move entries up, highest first, then drop the new record in
      S_SHIFT_UP: begin
        if (pend_q) mem_we_o = 1'b1;
        if (up_more) begin
          raddr     = idx_q - 1'b1;
          pend_d    = 1'b1;
          wr_addr_d = idx_q;
          idx_d     = idx_q - 1'b1;
        end else if (!pend_q) begin
          mem_we_o    = 1'b1;
          waddr       = at_q;
          mem_wdata_o = '{key: item_q.key, payload: item_q.payload};
          count_d     = count_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      // move entries down over the removed one, lowest first
      S_SHIFT_DN: begin
        if (pend_q) mem_we_o = 1'b1;
        if (dn_more) begin
          raddr     = idx_q + 1'b1;
          pend_d    = 1'b1;
          wr_addr_d = idx_q;
          idx_d     = idx_q + 1'b1;
        end else if (!pend_q) begin
          count_d = count_q - 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      // read ascending, compare the entry read in the previous cycle
      S_SCAN: begin
        if (scan_more) begin
          raddr     = idx_q;
          pend_d    = 1'b1;
          wr_addr_d = idx_q;
          idx_d     = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (key_hit) begin
          match_d = match_q + 1'b1;
          fkey_d  = mem_rdata_i.key;
          fpay_d  = mem_rdata_i.payload;
        end
        if (key_hit && item_q.op == OP_REMOVE_KEY) begin
          idx_d   = wr_addr_q;
          pend_d  = 1'b0;
          match_d = '0;
          fkey_d  = '0;
          fpay_d  = '0;
        end else if (!key_hit && !pend_q && !scan_more && item_q.op != OP_COUNT_KEY) begin
          status_d = ST_NOKEY;
        end
        if (item_q.op != OP_COUNT_KEY) match_d = '0;
        if (item_q.op != OP_FIND_KEY) begin
          fkey_d = '0;
          fpay_d = '0;
        end
      end
      S_FETCH: begin
        fkey_d = mem_rdata_i.key;
        fpay_d = mem_rdata_i.payload;
      end
      default: ;
    endcase
  end

  assign mem_waddr_o = AddrW'(waddr);
  assign mem_raddr_o = AddrW'(raddr);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept_i) item_q <= item_i;
    idx_q     <= idx_d;
    at_q      <= at_d;
    wr_addr_q <= wr_addr_d;
    status_q  <= status_d;
    fkey_q    <= fkey_d;
    fpay_q    <= fpay_d;
    match_q   <= match_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = '{status: status_q, found_key: fkey_q, found_payload: fpay_q,
                         match_count: match_q, list_length: count_q};

endmodule

// ----- sv/ordered_array_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// packed ordered list of key/payload records kept in one record memory,
// one operation per transaction
// ----------------------------------------------------------------------------
// The engine holds up to min(capacity_in_use, CAPACITY) records in order and
// runs one transaction at a time: insert, remove at a position, remove by key,
// find, read at a position, count matches, or clear; each gives exactly one
// result with a status and the new list length. Records live in one memory
// with one write and one read port, so every shift or search moves through
// the list one entry per cycle. A finished result sits in an output register,
// so the next transaction is taken while it waits. No clearing pass follows
// reset: the list starts empty and entries beyond the length are never read.
// Write capacity_in_use only while the engine is idle.
`include "ordered_array_list_engine_defines.svh"

module ordered_array_list_engine import oale_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [8:0]         position_i,
  input  logic signed [31:0] entry_key_i,
  input  logic [63:0]        entry_payload_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] found_key_o,
  output logic [63:0]        found_payload_o,
  output logic [8:0]         match_count_o,
  output logic [8:0]         list_length_o
);

  localparam int unsigned AddrW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CapLimitInt = (CAPACITY > 511) ? 511 : CAPACITY;
  localparam logic [CntW-1:0] CapLimit = CntW'(CapLimitInt);

  logic [CntW-1:0]  cap_q;
  logic             in_accept, busy;
  item_t            item;
  logic             res_valid, res_take;
  result_t          res, out_q;
  logic             out_valid_q, out_valid_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  rec_t             mem_wdata, mem_rdata;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 9'd256;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // input transaction
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;
  assign item       = '{op: op_e'(op_i), position: position_i, key: entry_key_i,
                        payload: entry_payload_i};

  oale_seq #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (item),
    .cap_i       (cap_q),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  oale_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_q <= res;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign found_key_o     = out_q.found_key;
  assign found_payload_o = out_q.found_payload;
  assign match_count_o   = out_q.match_count;
  assign list_length_o   = out_q.list_length;

  // assertions
  `OALE_ASSERT_ALWAYS(a_no_write_idle, !in_stall_o |-> !mem_we, "memory written while idle")
  `OALE_ASSERT(a_len_bound, out_valid_o |-> list_length_o <= CapLimit, "list length past limit")
  `OALE_ASSERT(a_fail_zero, out_valid_o && status_o != ST_OK |-> found_key_o == '0 && found_payload_o == '0 && match_count_o == '0, "failed result carries data")
  `OALE_ASSERT(a_res_from_busy, $rose(out_valid_o) |-> $past(in_stall_o), "result without work")

endmodule

// ----- dv/oale_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_list_checker
// watches both channels of the ordered list engine, keeps a shadow copy of
// the list and compares every result transaction with the shadow outcome
// ----------------------------------------------------------------------------
module oale_list_checker import oale_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         op_i,
  input  logic [8:0]         position_i,
  input  logic signed [31:0] entry_key_i,
  input  logic [63:0]        entry_payload_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         status_i,
  input  logic signed [31:0] found_key_i,
  input  logic [63:0]        found_payload_i,
  input  logic [8:0]         match_count_i,
  input  logic [8:0]         list_length_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        pending_count_o,
  output int unsigned        checked_count_o
);

  localparam int unsigned MaxReports = 10;

  // shadow copy of the record list
  logic signed [KeyW-1:0] shadow_keys     [CAPACITY];
  logic [PayW-1:0]        shadow_payloads [CAPACITY];
  int unsigned            shadow_len;
  logic [8:0]             shadow_cap;

  // outcomes of accepted operations, oldest first
  result_t op_results_q [$];

  // close the gap left by the record at position at
  task automatic drop_entry(input int unsigned at);
    for (int unsigned i = at; i + 1 < shadow_len; i++) begin
      shadow_keys[i]     = shadow_keys[i+1];
      shadow_payloads[i] = shadow_payloads[i+1];
    end
    shadow_len--;
  endtask

  // lowest position holding key
  function automatic bit first_key_at(input logic signed [KeyW-1:0] key,
                                      output int unsigned at);
    at = 0;
    for (int unsigned i = 0; i < shadow_len; i++) begin
      if (shadow_keys[i] == key) begin
        at = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // apply one operation to the shadow list and work out its result
  task automatic apply_list_op(input logic [2:0] op, input logic [8:0] pos,
                               input logic signed [KeyW-1:0] key,
                               input logic [PayW-1:0] payload,
                               output result_t res);
    int unsigned lim;
    int unsigned at;
    lim = (shadow_cap < CAPACITY) ? shadow_cap : CAPACITY;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= lim) begin
          res.status = ST_FULL;
        end else if (pos > lim) begin
          res.status = ST_BADPOS;
        end else begin
          at = (pos < shadow_len) ? pos : shadow_len;
          for (int unsigned i = shadow_len; i > at; i--) begin
            shadow_keys[i]     = shadow_keys[i-1];
            shadow_payloads[i] = shadow_payloads[i-1];
          end
          shadow_keys[at]     = key;
          shadow_payloads[at] = payload;
          shadow_len++;
        end
      end
      OP_REMOVE_AT: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= lim) begin
          res.status = ST_BADPOS;
        end else begin
          drop_entry((pos < shadow_len) ? pos : shadow_len - 1);
        end
      end
      OP_REMOVE_KEY: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (first_key_at(key, at)) begin
          drop_entry(at);
        end else begin
          res.status = ST_NOKEY;
        end
      end
      OP_FIND_KEY: begin
        if (first_key_at(key, at)) begin
          res.found_key     = shadow_keys[at];
          res.found_payload = shadow_payloads[at];
        end else begin
          res.status = ST_NOKEY;
        end
      end
      OP_READ_AT: begin
        if (pos == 0 || pos > shadow_len) begin
          res.status = ST_BADPOS;
        end else begin
          res.found_key     = shadow_keys[pos-1];
          res.found_payload = shadow_payloads[pos-1];
        end
      end
      OP_COUNT_KEY: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < shadow_len; i++) begin
            if (shadow_keys[i] == key) res.match_count = res.match_count + 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
        // unassigned code leaves the list alone
      end
    endcase
    res.list_length = shadow_len[8:0];
  endtask

  // sample at the falling edge: whatever handshakes are up here complete at
  // the next rising edge, and nothing changes in between
  always @(negedge clk_i) begin
    result_t expected;
    result_t actual;
    if (!rst_ni) begin
      shadow_len = 0;
      shadow_cap = 9'd256;
      op_results_q.delete();
      mismatch_count_o = 0;
      checked_count_o  = 0;
    end else begin
      // register write
      if (cfg_we_i) shadow_cap = cfg_wdata_i;

      // result transaction
      if (out_valid_i && !out_stall_i) begin
        actual.status        = status_e'(status_i);
        actual.found_key     = found_key_i;
        actual.found_payload = found_payload_i;
        actual.match_count   = match_count_i;
        actual.list_length   = list_length_i;
        checked_count_o++;
        if (op_results_q.size() == 0) begin
          if (mismatch_count_o < MaxReports) begin
            $display("%t: result with no operation outstanding: status %0d length %0d",
                     $time, status_i, list_length_i);
          end
          mismatch_count_o++;
        end else begin
          expected = op_results_q.pop_front();
          if (actual.status !== expected.status ||
              actual.found_key !== expected.found_key ||
              actual.found_payload !== expected.found_payload ||
              actual.match_count !== expected.match_count ||
              actual.list_length !== expected.list_length) begin
            if (mismatch_count_o < MaxReports) begin
              $display("%t: result %0d mismatch", $time, checked_count_o);
              $display("  expected status %0d key %0d payload %h count %0d length %0d",
                       expected.status, expected.found_key, expected.found_payload,
                       expected.match_count, expected.list_length);
              $display("  actual   status %0d key %0d payload %h count %0d length %0d",
                       actual.status, actual.found_key, actual.found_payload,
                       actual.match_count, actual.list_length);
            end
            mismatch_count_o++;
          end
        end
      end

      // operation transaction
      if (in_valid_i && !in_stall_i) begin
        apply_list_op(op_i, position_i, entry_key_i, entry_payload_i, expected);
        op_results_q.push_back(expected);
      end
    end
    pending_count_o = op_results_q.size();
  end

endmodule

// ----- dv/tb_ordered_array_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_array_list_engine
// drives operations and register writes into the ordered list engine
// ----------------------------------------------------------------------------
// A directed opening walks the empty, bad position, append, duplicate key and
// unassigned code cases, then random phases run under several capacities
// (0, 1, 4, 37, 256) with a small key set so finds, counts and removes hit.
// Both channels idle at random; one long output hold-off backs the engine up.
// The checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ordered_array_list_engine;
  import oale_pkg::*;

  localparam int unsigned Capacity    = 256;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 1_000_000;

  localparam logic [2:0]        OpUnassigned = 3'd7;
  localparam logic signed [31:0] KeyMin      = 32'sh8000_0000;
  localparam logic signed [31:0] KeyMax      = 32'sh7fff_ffff;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [8:0]         cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic [2:0]         op_i            = '0;
  logic [8:0]         position_i      = '0;
  logic signed [31:0] entry_key_i     = '0;
  logic [63:0]        entry_payload_i = '0;
  logic               out_stall_i     = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [2:0]         status_o;
  logic signed [31:0] found_key_o;
  logic [63:0]        found_payload_o;
  logic [8:0]         match_count_o;
  logic [8:0]         list_length_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;

  int unsigned sender_idle_pct   = 34;
  int unsigned receiver_idle_pct = 64;
  int unsigned sender_calm       = 0;
  int unsigned items_sent        = 0;
  int unsigned settings_used     = 0;
  int unsigned cycle_count       = 0;
  logic [8:0]  cur_cap           = 9'd256;
  logic        hold_req          = 1'b0;

  ordered_array_list_engine #(.CAPACITY(Capacity)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .position_i      (position_i),
    .entry_key_i     (entry_key_i),
    .entry_payload_i (entry_payload_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_key_o     (found_key_o),
    .found_payload_o (found_payload_o),
    .match_count_o   (match_count_o),
    .list_length_o   (list_length_o)
  );

  oale_list_checker #(.CAPACITY(Capacity)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .op_i             (op_i),
    .position_i       (position_i),
    .entry_key_i      (entry_key_i),
    .entry_payload_i  (entry_payload_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .found_key_i      (found_key_o),
    .found_payload_i  (found_payload_o),
    .match_count_i    (match_count_o),
    .list_length_i    (list_length_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("ordered_array_list_engine test failed");
      $finish;
    end
  end

  // output side stalls, with calm stretches and one long hold-off on request
  initial begin : result_stall_gen
    int unsigned calm;
    calm = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (calm > 0) begin
        calm--;
        out_stall_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 3) calm = 40;
        out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
    end
  end

  // offer one operation transaction and wait until it is taken
  task automatic send_item(input logic [2:0] op, input logic [8:0] pos,
                           input logic signed [31:0] key, input logic [63:0] payload);
    bit taken;
    if (sender_calm > 0) begin
      sender_calm--;
    end else begin
      if ($urandom_range(0, 99) < 3) sender_calm = 30;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    position_i      <= pos;
    entry_key_i     <= key;
    entry_payload_i <= payload;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  // hold the input side until every result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // capacity register write, only with the engine idle
  task automatic write_capacity(input logic [8:0] value);
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cap = value;
    settings_used++;
  endtask

  // small key set so that searches and counts find something
  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] key;
    case ($urandom_range(0, 9))
      0:       key = KeyMin;
      1:       key = KeyMax;
      2:       key = '0;
      3:       key = '1;
      4:       key = 32'sd7;
      5:       key = 32'sd42;
      6:       key = 32'sh5a5a_a5a5;
      default: key = $urandom;
    endcase
    return key;
  endfunction

  // mostly near the front, some around the capacity, a few anywhere
  function automatic logic [8:0] pick_position();
    int unsigned roll;
    logic [8:0]  pos;
    roll = $urandom_range(0, 99);
    if (roll < 45)      pos = 9'($urandom_range(0, 6));
    else if (roll < 70) pos = 9'($urandom_range(0, cur_cap + 32'd1));
    else if (roll < 78) pos = cur_cap;
    else if (roll < 85) pos = cur_cap - 1'b1;
    else                pos = 9'($urandom);
    return pos;
  endfunction

  // random operation mix; hold_at picks the transaction that starts the hold-off
  task automatic run_random(input int unsigned count, input int unsigned insert_pct,
                            input int unsigned hold_at);
    logic [2:0]  op;
    int unsigned roll;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == hold_at) hold_req <= 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        op = OP_INSERT;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 2)      op = OpUnassigned;
        else if (roll < 6) op = OP_CLEAR;
        else begin
          case ($urandom_range(0, 4))
            0:       op = OP_REMOVE_AT;
            1:       op = OP_REMOVE_KEY;
            2:       op = OP_FIND_KEY;
            3:       op = OP_READ_AT;
            default: op = OP_COUNT_KEY;
          endcase
        end
      end
      send_item(op, pick_position(), pick_key(), {$urandom, $urandom});
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, appends, bad positions, duplicates, clear
    send_item(OP_COUNT_KEY,  9'd0,   '0,            '0);
    send_item(OP_REMOVE_AT,  9'd0,   '0,            '0);
    send_item(OP_REMOVE_KEY, 9'd0,   KeyMax,        '0);
    send_item(OP_FIND_KEY,   9'd0,   KeyMax,        '0);
    send_item(OP_READ_AT,    9'd0,   '0,            '0);
    send_item(OP_READ_AT,    9'd1,   '0,            '0);
    send_item(OP_INSERT,     9'd0,   KeyMin,        '1);
    send_item(OP_INSERT,     9'd256, KeyMax,        '0);
    send_item(OP_INSERT,     9'd257, 32'sd7,        64'h0bad_0bad_0bad_0bad);
    send_item(OP_INSERT,     9'd0,   '0,            64'h0123_4567_89ab_cdef);
    send_item(OP_INSERT,     9'd1,   KeyMax,        {$urandom, $urandom});
    send_item(OP_READ_AT,    9'd1,   '0,            '0);
    send_item(OP_READ_AT,    9'd4,   '0,            '0);
    send_item(OP_READ_AT,    9'd5,   '0,            '0);
    send_item(OP_FIND_KEY,   9'd0,   KeyMax,        '0);
    send_item(OP_FIND_KEY,   9'd0,   32'sd12345,    '0);
    send_item(OP_COUNT_KEY,  9'd0,   KeyMax,        '0);
    send_item(OP_COUNT_KEY,  9'd0,   32'sd7,        '0);
    send_item(OP_REMOVE_KEY, 9'd0,   KeyMax,        '0);
    send_item(OP_REMOVE_AT,  9'd256, '0,            '0);
    send_item(OP_REMOVE_AT,  9'd100, '0,            '0);
    send_item(OP_REMOVE_AT,  9'd0,   '0,            '0);
    send_item(OpUnassigned,  9'd511, '1,            '1);
    send_item(OP_CLEAR,      9'd0,   '0,            '0);
    send_item(OP_READ_AT,    9'd1,   '0,            '0);

    // small capacities fill up fast
    write_capacity(9'd4);
    run_random(130, 45, 130);
    write_capacity(9'd1);
    run_random(60, 50, 60);

    // swap idling sides
    sender_idle_pct   = 64;
    receiver_idle_pct = 34;
    write_capacity(9'd0);
    run_random(10, 50, 10);
    write_capacity(9'd256);
    run_random(100, 60, 100);
    wait_drained();
    run_random(100, 60, 20);

    // full rate on both sides
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    write_capacity(9'd37);
    run_random(140, 55, 140);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("ran %0d operations over %0d capacity settings (0 to 256), with a long hold-off",
             items_sent, settings_used + 1);
    $display("checked %0d results, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("ordered_array_list_engine test passed");
    end else begin
      $display("ordered_array_list_engine test failed");
    end
    $finish;
  end

endmodule
